@@ rtl/lsrq_pkg.sv @@
package lsrq_pkg;

  typedef enum logic [1:0] {
    FUNC_PUSH  = 2'd0,
    FUNC_POP   = 2'd1,
    FUNC_RANGE = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    KIND_POPPED    = 2'd0,
    KIND_POP_EMPTY = 2'd1,
    KIND_RANGE     = 2'd2
  } kind_e;

  localparam int unsigned DataW   = 32;
  localparam int unsigned ResultW = 33;

  localparam logic signed [DataW-1:0] MaxSeed = 32'sd0;
  localparam logic signed [DataW-1:0] MinSeed = 32'sd100000;

  typedef struct packed {
    logic start;
    logic sample;
  } scan_ctl_t;

endpackage

@@ rtl/lsrq_ram.sv @@
module lsrq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/lsrq_scan.sv @@
module lsrq_scan (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  lsrq_pkg::scan_ctl_t                   ctl_i,
  input  logic signed [lsrq_pkg::DataW-1:0]     sample_i,
  output logic signed [lsrq_pkg::ResultW-1:0]   range_o
);

  logic signed [lsrq_pkg::DataW-1:0] hi_q, hi_d;
  logic signed [lsrq_pkg::DataW-1:0] lo_q, lo_d;

  always_comb begin
    hi_d = hi_q;
    lo_d = lo_q;
    if (ctl_i.start) begin
      hi_d = lsrq_pkg::MaxSeed;
      lo_d = lsrq_pkg::MinSeed;
    end else if (ctl_i.sample) begin
      if (sample_i > hi_q) begin
        hi_d = sample_i;
      end
      if (sample_i < lo_q) begin
        lo_d = sample_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hi_q <= lsrq_pkg::MaxSeed;
      lo_q <= lsrq_pkg::MinSeed;
    end else begin
      hi_q <= hi_d;
      lo_q <= lo_d;
    end
  end

  assign range_o = {hi_q[lsrq_pkg::DataW-1], hi_q} - {lo_q[lsrq_pkg::DataW-1], lo_q};

endmodule

@@ rtl/lifo_stack_with_range_query_unit.sv @@
// Channel  Dir  tdata                     tuser
// s_axis   in   [31:0] push_value         [1:0] func
// m_axis   out  [32:0] result_value       [1:0] result_kind
//
// Push and unused codes complete in the idle state; pop makes one RAM read and
// passes through the pop and emit states, or goes straight to emit when empty.
// Range: the scan reads one stack entry per cycle through the single RAM read
// port; the drain state then forms max minus min, with max seeded 0 and min 100000.
// Reset clears the entry count and the control state; RAM contents are not cleared.
// A finished result sits in the output register; a new item is taken while it waits,
// and a later result stalls only until that register is free.
module lifo_stack_with_range_query_unit #(
  parameter int unsigned STACK_DEPTH = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [31:0] push_value
  input  logic [1:0]  s_axis_tuser_i,   // [1:0] func
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // [32:0] result_value, [39:33] zero
  output logic [1:0]  m_axis_tuser_o    // [1:0] result_kind
);

  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned DW = lsrq_pkg::DataW;
  localparam int unsigned RW = lsrq_pkg::ResultW;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POP,
    ST_SCAN,
    ST_DRAIN,
    ST_EMIT
  } state_e;

  state_e                state_q, state_d;
  logic [CW-1:0]         count_q, count_d;
  logic [CW-1:0]         idx_q, idx_d;
  logic                  rd_vld_q, rd_vld_d;
  logic [RW-1:0]         res_q, res_d;
  lsrq_pkg::kind_e       kind_q, kind_d;
  logic                  m_valid_q, m_valid_d;
  logic [RW-1:0]         m_data_q, m_data_d;
  lsrq_pkg::kind_e       m_kind_q, m_kind_d;

  logic                  in_xfer;
  lsrq_pkg::func_e       func;
  logic                  we;
  logic [AW-1:0]         waddr;
  logic                  re;
  logic [AW-1:0]         raddr;
  logic [DW-1:0]         rdata;
  lsrq_pkg::scan_ctl_t   scan_ctl;
  logic signed [RW-1:0]  range;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;
  assign func            = lsrq_pkg::func_e'(s_axis_tuser_i);

  lsrq_ram #(
    .WIDTH(DW),
    .DEPTH(STACK_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(s_axis_tdata_i),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  lsrq_scan u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (scan_ctl),
    .sample_i(rdata),
    .range_o (range)
  );

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    idx_d     = idx_q;
    rd_vld_d  = 1'b0;
    res_d     = res_q;
    kind_d    = kind_q;
    m_valid_d = m_valid_q && !m_axis_tready_i;
    m_data_d  = m_data_q;
    m_kind_d  = m_kind_q;
    we        = 1'b0;
    waddr     = count_q[AW-1:0];
    re        = 1'b0;
    raddr     = idx_q[AW-1:0];
    scan_ctl  = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          case (func)
            lsrq_pkg::FUNC_PUSH: begin
              if (count_q < CW'(STACK_DEPTH)) begin
                we      = 1'b1;
                count_d = count_q + 1'b1;
              end
            end
            lsrq_pkg::FUNC_POP: begin
              if (count_q == '0) begin
                res_d   = '0;
                kind_d  = lsrq_pkg::KIND_POP_EMPTY;
                state_d = ST_EMIT;
              end else begin
                re      = 1'b1;
                raddr   = AW'(count_q - 1'b1);
                count_d = count_q - 1'b1;
                state_d = ST_POP;
              end
            end
            lsrq_pkg::FUNC_RANGE: begin
              scan_ctl.start = 1'b1;
              if (count_q == '0) begin
                state_d = ST_DRAIN;
              end else begin
                re       = 1'b1;
                raddr    = '0;
                idx_d    = CW'(1);
                rd_vld_d = 1'b1;
                state_d  = ST_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_POP: begin
        res_d   = {rdata[DW-1], rdata};
        kind_d  = lsrq_pkg::KIND_POPPED;
        state_d = ST_EMIT;
      end
      ST_SCAN: begin
        scan_ctl.sample = rd_vld_q;
        if (idx_q < count_q) begin
          re       = 1'b1;
          idx_d    = idx_q + 1'b1;
          rd_vld_d = 1'b1;
        end else begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        res_d   = range;
        kind_d  = lsrq_pkg::KIND_RANGE;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (!m_valid_q || m_axis_tready_i) begin
          m_valid_d = 1'b1;
          m_data_d  = res_q;
          m_kind_d  = kind_q;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      idx_q     <= '0;
      rd_vld_q  <= 1'b0;
      m_valid_q <= 1'b0;
      res_q     <= '0;
      kind_q    <= lsrq_pkg::KIND_POPPED;
      m_data_q  <= '0;
      m_kind_q  <= lsrq_pkg::KIND_POPPED;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      idx_q     <= idx_d;
      rd_vld_q  <= rd_vld_d;
      m_valid_q <= m_valid_d;
      res_q     <= res_d;
      kind_q    <= kind_d;
      m_data_q  <= m_data_d;
      m_kind_q  <= m_kind_d;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {7'd0, m_data_q};
  assign m_axis_tuser_o  = m_kind_q;

endmodule
